FILE: rtl/radar_blip_placer_core_macros.svh
// Assertion macros shared by the radar blip placer checker.
// Depends on nothing; included by files that assert.
`ifndef RADAR_BLIP_PLACER_CORE_MACROS_SVH
`define RADAR_BLIP_PLACER_CORE_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define RBP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define RBP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

FILE: rtl/rbp_pkg.sv
// Package for the radar blip placer: register indexes, widths, arctangent table.
// Depends on nothing.
package rbp_pkg;
    localparam int W = 56;          // CORDIC datapath width (Q.12 pixels)
    localparam int ATAN_N = 24;
    localparam logic [31:0] GAIN_Q24 = 32'd10188014;

    typedef enum logic [2:0] {
        REG_SCALE = 3'd0, REG_RADIUS = 3'd1, REG_CX = 3'd2,
        REG_CY = 3'd3, REG_HW = 3'd4, REG_HH = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [15:0] scale;
        logic [9:0]  radius;
        logic [11:0] cx;
        logic [11:0] cy;
        logic [7:0]  hw;
        logic [7:0]  hh;
    } t_cfg;

    function automatic logic [31:0] atan_f(input logic [4:0] i);
        logic [31:0] r;
        begin
            unique case (i)
                5'd0: r = 32'h20000000; 5'd1: r = 32'h12E4051E; 5'd2: r = 32'h09FB385B;
                5'd3: r = 32'h051111D4; 5'd4: r = 32'h028B0D43; 5'd5: r = 32'h0145D7E1;
                5'd6: r = 32'h00A2F61E; 5'd7: r = 32'h00517C55; 5'd8: r = 32'h0028BE53;
                5'd9: r = 32'h00145F2F; 5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
                5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3; 5'd14: r = 32'h0000A2FA;
                5'd15: r = 32'h0000517D; 5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
                5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518; 5'd20: r = 32'h0000028C;
                5'd21: r = 32'h00000146; 5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
                default: r = 32'h0;
            endcase
            return r;
        end
    endfunction
endpackage

FILE: rtl/rbp_cordic_stage.sv
// One CORDIC micro-rotation with its output register, vectoring or rotation mode.
// Depends on rbp_pkg for the datapath width and arctangent table.
module rbp_cordic_stage #(
    parameter int IDX = 0,
    parameter int SW = 64
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic                   i_vec,
    input  logic signed [rbp_pkg::W-1:0] i_x,
    input  logic signed [rbp_pkg::W-1:0] i_y,
    input  logic [32:0]            i_z,
    input  logic [SW-1:0]          i_side,
    output logic signed [rbp_pkg::W-1:0] o_x,
    output logic signed [rbp_pkg::W-1:0] o_y,
    output logic [32:0]            o_z,
    output logic [SW-1:0]          o_side
);
    localparam logic [31:0] A = rbp_pkg::atan_f(5'(IDX));
    logic pos;
    logic signed [rbp_pkg::W-1:0] xs, ys;
    assign xs = i_x >>> IDX;
    assign ys = i_y >>> IDX;
    // Vectoring drives y to zero; rotation drives the residual angle to zero.
    assign pos = i_vec ? ~i_y[rbp_pkg::W-1] : ~i_z[32];
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_side <= i_side;
            if (pos ^ i_vec) begin
                o_x <= i_x - ys;
                o_y <= i_y + xs;
            end else begin
                o_x <= i_x + ys;
                o_y <= i_y - xs;
            end
            if (pos) o_z <= i_vec ? i_z + {1'b0, A} : i_z - {1'b0, A};
            else     o_z <= i_vec ? i_z - {1'b0, A} : i_z + {1'b0, A};
        end
    end
endmodule

FILE: rtl/radar_blip_placer_core.sv
// Top level of the radar blip placer: config registers and the full pipeline.
// Depends on rbp_pkg and rbp_cordic_stage.
// Throughput: one beat per cycle; a stall at the output freezes every stage.
// Reset: registers return to defaults, all valid bits clear, synchronous.
module radar_blip_placer_core #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic signed [23:0] i_target_x,
    input  logic signed [23:0] i_target_z,
    input  logic signed [23:0] i_observer_x,
    input  logic signed [23:0] i_observer_z,
    input  logic [15:0] i_camera_yaw,
    output logic        o_valid,
    input  logic        i_stall,
    output logic signed [15:0] o_pixel_x,
    output logic signed [15:0] o_pixel_y,
    output logic        o_clamped
);
    localparam int N = (CORDIC_STAGES < rbp_pkg::ATAN_N) ? CORDIC_STAGES : rbp_pkg::ATAN_N;
    localparam int W = rbp_pkg::W;

    rbp_pkg::t_cfg r_cfg;
    logic [2:0] widx;
    assign widx = paddr[4:2];
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{scale: 16'd6554, radius: 10'd64, cx: 12'd64, cy: 12'd64,
                       hw: 8'd4, hh: 8'd4};
        end else if (psel && penable && pwrite) begin
            unique case (widx)
                rbp_pkg::REG_SCALE:  r_cfg.scale  <= pwdata[15:0];
                rbp_pkg::REG_RADIUS: r_cfg.radius <= pwdata[9:0];
                rbp_pkg::REG_CX:     r_cfg.cx     <= pwdata[11:0];
                rbp_pkg::REG_CY:     r_cfg.cy     <= pwdata[11:0];
                rbp_pkg::REG_HW:     r_cfg.hw     <= pwdata[7:0];
                rbp_pkg::REG_HH:     r_cfg.hh     <= pwdata[7:0];
                default: ;
            endcase
        end
    end
    always_comb begin
        unique case (widx)
            rbp_pkg::REG_SCALE:  prdata = {16'd0, r_cfg.scale};
            rbp_pkg::REG_RADIUS: prdata = {22'd0, r_cfg.radius};
            rbp_pkg::REG_CX:     prdata = {20'd0, r_cfg.cx};
            rbp_pkg::REG_CY:     prdata = {20'd0, r_cfg.cy};
            rbp_pkg::REG_HW:     prdata = {24'd0, r_cfg.hw};
            rbp_pkg::REG_HH:     prdata = {24'd0, r_cfg.hh};
            default:             prdata = 32'd0;
        endcase
    end

    // Whole pipeline advances together; a stalled output holds every stage.
    localparam int DEPTH = 2 * N + 9;
    logic adv;
    logic [DEPTH-1:0] r_v;
    assign adv = !(o_valid && i_stall);
    assign o_stall = !adv;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v <= '0;
        else if (adv) r_v <= {r_v[DEPTH-2:0], i_valid};
    end
    assign o_valid = r_v[DEPTH-1];

    // Stage 1: differences.
    logic signed [24:0] r_dx, r_dy;
    logic [15:0] r_yaw1;
    always_ff @(posedge i_clk) if (adv) begin
        r_dx <= 25'(i_target_x) - 25'(i_observer_x);
        r_dy <= 25'(i_observer_z) - 25'(i_target_z);
        r_yaw1 <= i_camera_yaw;
    end
    // Stage 2: scale products.
    logic signed [41:0] r_px, r_py;
    logic [15:0] r_yaw2;
    always_ff @(posedge i_clk) if (adv) begin
        r_px <= 42'(r_dx * $signed({1'b0, r_cfg.scale}));
        r_py <= 42'(r_dy * $signed({1'b0, r_cfg.scale}));
        r_yaw2 <= r_yaw1;
    end
    // Stage 3: rounding.
    logic signed [30:0] r_sx, r_sy;
    logic [15:0] r_yaw3;
    always_ff @(posedge i_clk) if (adv) begin
        r_sx <= 31'((r_px + 42'sd2048) >>> 12);
        r_sy <= 31'((r_py + 42'sd2048) >>> 12);
        r_yaw3 <= r_yaw2;
    end
    // Stage 4: squares.
    logic [61:0] r_qx, r_qy;
    logic signed [30:0] r_sx4, r_sy4;
    logic [15:0] r_yaw4;
    always_ff @(posedge i_clk) if (adv) begin
        r_qx <= 62'(r_sx * r_sx);
        r_qy <= 62'(r_sy * r_sy);
        r_sx4 <= r_sx; r_sy4 <= r_sy; r_yaw4 <= r_yaw3;
    end
    // Stage 5: clamp decision and vectoring pre-rotation.
    logic r_cl5;
    logic signed [W-1:0] r_vx5, r_vy5;
    logic [32:0] r_vz5;
    logic signed [W-1:0] sxw, syw;
    logic [43:0] rr;
    logic [19:0] rad_sq;
    logic [15:0] r_yaw5;
    logic signed [W-1:0] r_ox5, r_oy5;
    assign sxw = W'(r_sx4);
    assign syw = W'(r_sy4);
    assign rr = 44'(r_cfg.radius) << 12;
    // The squared rim radius in Q.24 is the integer square shifted up by 24.
    assign rad_sq = r_cfg.radius * r_cfg.radius;
    always_ff @(posedge i_clk) if (adv) begin
        r_cl5 <= (63'(r_qx) + 63'(r_qy)) > 63'({rad_sq, 24'd0});
        r_ox5 <= sxw; r_oy5 <= syw;
        r_yaw5 <= r_yaw4;
        if (r_sx4 < 0) begin
            r_vx5 <= -sxw; r_vy5 <= -syw; r_vz5 <= 33'h080000000;
        end else begin
            r_vx5 <= sxw; r_vy5 <= syw; r_vz5 <= '0;
        end
    end

    // Vectoring CORDIC; side band carries clamp, yaw and the unclamped vector.
    localparam int SB = 1 + 16 + 2 * W;
    logic signed [W-1:0] vx [N+1];
    logic signed [W-1:0] vy [N+1];
    logic [32:0] vz [N+1];
    logic [SB-1:0] vs [N+1];
    assign vx[0] = r_vx5; assign vy[0] = r_vy5; assign vz[0] = r_vz5;
    assign vs[0] = {r_cl5, r_yaw5, r_ox5, r_oy5};
    for (genvar g = 0; g < N; g++) begin : g_vec
        rbp_cordic_stage #(.IDX(g), .SW(SB)) u_st (
            .i_clk(i_clk), .i_en(adv), .i_vec(1'b1),
            .i_x(vx[g]), .i_y(vy[g]), .i_z(vz[g]), .i_side(vs[g]),
            .o_x(vx[g+1]), .o_y(vy[g+1]), .o_z(vz[g+1]), .o_side(vs[g+1]));
    end

    // Stage: select vector and angle, with half-turn pre-rotation.
    logic cl_v;
    logic [15:0] yaw_v;
    logic signed [W-1:0] ox_v, oy_v, sel_x, sel_y;
    logic [31:0] rot, ang;
    assign {cl_v, yaw_v, ox_v, oy_v} = vs[N];
    assign rot = {16'(16'd0 - yaw_v), 16'd0};
    assign ang = cl_v ? vz[N][31:0] + rot : rot;
    assign sel_x = cl_v ? W'(rr) : ox_v;
    assign sel_y = cl_v ? '0 : oy_v;
    logic signed [W-1:0] r_rx, r_ry;
    logic [32:0] r_rz;
    logic r_clr;
    always_ff @(posedge i_clk) if (adv) begin
        r_clr <= cl_v;
        if (ang[31] ^ ang[30]) begin
            r_rx <= -sel_x; r_ry <= -sel_y;
            r_rz <= {~ang[31], ~ang[31], ang[30:0]};
        end else begin
            r_rx <= sel_x; r_ry <= sel_y;
            r_rz <= {ang[31], ang};
        end
    end

    logic signed [W-1:0] rx [N+1];
    logic signed [W-1:0] ry [N+1];
    logic [32:0] rz [N+1];
    logic rs [N+1];
    assign rx[0] = r_rx; assign ry[0] = r_ry; assign rz[0] = r_rz; assign rs[0] = r_clr;
    for (genvar g = 0; g < N; g++) begin : g_rot
        logic [0:0] so;
        rbp_cordic_stage #(.IDX(g), .SW(1)) u_st (
            .i_clk(i_clk), .i_en(adv), .i_vec(1'b0),
            .i_x(rx[g]), .i_y(ry[g]), .i_z(rz[g]), .i_side(rs[g]),
            .o_x(rx[g+1]), .o_y(ry[g+1]), .o_z(rz[g+1]), .o_side(so));
        assign rs[g+1] = so[0];
    end

    // Gain removal: CORDIC output stays below about 2^31, so the multiply is
    // split into a small signed high part and an unsigned 24-bit low part.
    logic signed [W-1:0] r_gx_lo, r_gx_hi, r_gy_lo, r_gy_hi;
    logic r_cg;
    logic signed [15:0] xh, yh;
    logic [23:0] xl, yl;
    assign xh = 16'(rx[N] >>> 24);
    assign yh = 16'(ry[N] >>> 24);
    assign xl = rx[N][23:0];
    assign yl = ry[N][23:0];
    always_ff @(posedge i_clk) if (adv) begin
        r_gx_hi <= W'(xh * $signed({1'b0, rbp_pkg::GAIN_Q24[23:0]}));
        r_gy_hi <= W'(yh * $signed({1'b0, rbp_pkg::GAIN_Q24[23:0]}));
        r_gx_lo <= W'({1'b0, xl} * {1'b0, rbp_pkg::GAIN_Q24[23:0]});
        r_gy_lo <= W'({1'b0, yl} * {1'b0, rbp_pkg::GAIN_Q24[23:0]});
        r_cg <= rs[N];
    end
    logic signed [W-1:0] r_fx, r_fy;
    logic r_cf;
    logic signed [W-1:0] lx, ly;
    assign lx = (r_gx_lo + W'(32'sd8388608)) >>> 24;
    assign ly = (r_gy_lo + W'(32'sd8388608)) >>> 24;
    always_ff @(posedge i_clk) if (adv) begin
        r_fx <= r_gx_hi + lx;
        r_fy <= r_gy_hi + ly;
        r_cf <= r_cg;
    end
    // Final: Q.4 rounding, offset, saturation.
    logic signed [W-1:0] ax, ay;
    assign ax = ((r_fx + W'(128)) >>> 8) + $signed(W'({r_cfg.cx, 4'd0}))
              - $signed(W'({r_cfg.hw, 4'd0}));
    assign ay = ((r_fy + W'(128)) >>> 8) + $signed(W'({r_cfg.cy, 4'd0}))
              - $signed(W'({r_cfg.hh, 4'd0}));
    always_ff @(posedge i_clk) if (adv) begin
        o_pixel_x <= (ax > W'(32767)) ? 16'sh7FFF : (ax < -W'(32768)) ? 16'sh8000 : ax[15:0];
        o_pixel_y <= (ay > W'(32767)) ? 16'sh7FFF : (ay < -W'(32768)) ? 16'sh8000 : ay[15:0];
        o_clamped <= r_cf;
    end
endmodule

FILE: rtl/rbp_checker.sv
// Port-level checker for the radar blip placer, bound to the top level.
// Depends on radar_blip_placer_core_macros.svh.
`include "radar_blip_placer_core_macros.svh"
module rbp_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_stall,
    input logic o_valid,
    input logic i_stall,
    input logic o_clamped,
    input logic pready
);
    `RBP_ASSERT_IMP(a_stall_only_on_out, i_clk, i_rst_n, o_stall, o_valid && i_stall)
    `RBP_ASSERT_NEXT(a_out_holds, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_clamped))
    `RBP_ASSERT_IMP(a_ready, i_clk, i_rst_n, 1'b1, pready)
endmodule
bind radar_blip_placer_core rbp_checker u_rbp_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_clamped(o_clamped), .pready(pready));

FILE: tb/tb_radar_blip_placer_core.sv
// Self-checking testbench for radar_blip_placer_core: random and directed blips checked
// against a bit-exact fixed-point predictor with APB register phases.
// Depends on rbp_pkg and the radar_blip_placer_core RTL.
`timescale 1ns / 1ps

module tb_radar_blip_placer_core;

    localparam int STAGES = 16;
    localparam int NSTG = (STAGES < 24) ? STAGES : 24;
    localparam int LATENCY = 2 * NSTG + 9;

    typedef struct {
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic               clamped;
    } blip_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic i_valid = 1'b0;
    logic o_stall;
    logic signed [23:0] i_target_x = '0, i_target_z = '0, i_observer_x = '0, i_observer_z = '0;
    logic [15:0] i_camera_yaw = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic signed [15:0] o_pixel_x, o_pixel_y;
    logic o_clamped;

    radar_blip_placer_core #(.CORDIC_STAGES(STAGES)) DUT (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor copy of the register file.
    longint cfg_scale = 6554, cfg_radius = 64, cfg_cx = 64, cfg_cy = 64, cfg_hw = 4, cfg_hh = 4;

    blip_t expected_blips[$];
    int errors = 0;
    bit send_gaps = 1'b1;
    bit sink_gaps = 1'b1;
    int hold_cycles = 0;

    localparam logic [31:0] ATAN_TAB[24] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
        32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
        32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};

    function automatic longint round_shift(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic logic [15:0] saturate16(longint v);
        if (v > 32767) return 16'h7FFF;
        if (v < -32768) return 16'h8000;
        return v[15:0];
    endfunction

    function automatic logic [31:0] vector_heading(longint x, longint y);
        logic [31:0] z = '0;
        longint xs, ys;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = 32'h80000000;
        end
        for (int i = 0; i < NSTG; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_TAB[i];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_TAB[i];
            end
        end
        return z;
    endfunction

    function automatic void rotate_vector(inout longint x, inout longint y,
                                          input logic [31:0] ang);
        longint z, xs, ys;
        if (ang[31:30] == 2'd1 || ang[31:30] == 2'd2) begin
            x = -x;
            y = -y;
            ang[31] = ~ang[31];
        end
        z = longint'(signed'(ang));
        for (int i = 0; i < NSTG; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys;
                y = y + xs;
                z = z - longint'(ATAN_TAB[i]);
            end else begin
                x = x + ys;
                y = y - xs;
                z = z + longint'(ATAN_TAB[i]);
            end
        end
        x = round_shift(x * longint'(rbp_pkg::GAIN_Q24), 24);
        y = round_shift(y * longint'(rbp_pkg::GAIN_Q24), 24);
    endfunction

    function automatic blip_t place_blip(logic signed [23:0] tx, logic signed [23:0] tz,
                                         logic signed [23:0] ox, logic signed [23:0] oz,
                                         logic [15:0] yaw);
        blip_t b;
        longint dx, dy, sx, sy, r12, vx, vy;
        logic [31:0] rot, ang;
        logic [15:0] nyaw;
        bit pin;
        dx = longint'(tx) - longint'(ox);
        dy = longint'(oz) - longint'(tz);
        sx = round_shift(dx * cfg_scale, 12);
        sy = round_shift(dy * cfg_scale, 12);
        r12 = cfg_radius * 4096;
        nyaw = 16'd0 - yaw;
        rot = {nyaw, 16'd0};
        pin = (sx * sx + sy * sy) > r12 * r12;
        if (pin) begin
            ang = vector_heading(sx, sy) + rot;
            vx = r12;
            vy = 0;
        end else begin
            ang = rot;
            vx = sx;
            vy = sy;
        end
        rotate_vector(vx, vy, ang);
        b.px = saturate16(cfg_cx * 16 - cfg_hw * 16 + round_shift(vx, 8));
        b.py = saturate16(cfg_cy * 16 - cfg_hh * 16 + round_shift(vy, 8));
        b.clamped = pin;
        return b;
    endfunction

    task automatic write_reg(rbp_pkg::t_reg_idx idx, logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 5'(idx) << 2;
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            rbp_pkg::REG_SCALE:  cfg_scale = val[15:0];
            rbp_pkg::REG_RADIUS: cfg_radius = val[9:0];
            rbp_pkg::REG_CX:     cfg_cx = val[11:0];
            rbp_pkg::REG_CY:     cfg_cy = val[11:0];
            rbp_pkg::REG_HW:     cfg_hw = val[7:0];
            default:             cfg_hh = val[7:0];
        endcase
    endtask

    task automatic send_blip(logic signed [23:0] tx, logic signed [23:0] tz,
                             logic signed [23:0] ox, logic signed [23:0] oz, logic [15:0] yaw);
        int gap;
        if (send_gaps && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 4);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_target_x <= tx;
        i_target_z <= tz;
        i_observer_x <= ox;
        i_observer_z <= oz;
        i_camera_yaw <= yaw;
        do @(posedge i_clk); while (o_stall);
        expected_blips.push_back(place_blip(tx, tz, ox, oz, yaw));
    endtask

    task automatic end_burst();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        int guard = 0;
        while (expected_blips.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    function automatic logic signed [23:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return 24'(signed'($urandom));
            1: return 24'sd0 + 24'(int'($urandom_range(0, 8000)) - 4000);
            2: return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
            default: return 24'(int'($urandom_range(0, 200000)) - 100000);
        endcase
    endfunction

    task automatic send_random(int n);
        logic signed [23:0] ox, oz;
        for (int k = 0; k < n; k++) begin
            ox = rand_coord();
            oz = rand_coord();
            if ($urandom_range(0, 1))
                send_blip(ox + 24'(int'($urandom_range(0, 4000)) - 2000),
                          oz + 24'(int'($urandom_range(0, 4000)) - 2000),
                          ox, oz, 16'($urandom));
            else
                send_blip(rand_coord(), rand_coord(), ox, oz, 16'($urandom));
        end
        end_burst();
    endtask

    task automatic test_directed();
        logic [15:0] yaws[8] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                                 16'h3FFF, 16'h4001, 16'hBFFF, 16'hFFFF};
        send_blip(24'sd0, 24'sd0, 24'sd0, 24'sd0, 16'h0000);
        send_blip(24'sh7FFFFF, 24'sh800000, 24'sh800000, 24'sh7FFFFF, 16'hFFFF);
        send_blip(24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000, 16'h8000);
        foreach (yaws[i]) send_blip(24'sd2560, 24'sd1280, 24'sd0, 24'sd0, yaws[i]);
        foreach (yaws[i]) send_blip(24'sd50000, -24'sd70000, 24'sd0, 24'sd0, yaws[i]);
        end_burst();
        wait_drained();
    endtask

    task automatic test_extreme_config();
        // Zero radius pins every nonzero vector to the center.
        write_reg(rbp_pkg::REG_RADIUS, 32'd0);
        write_reg(rbp_pkg::REG_SCALE, 32'hFFFF);
        write_reg(rbp_pkg::REG_CX, 32'd0);
        write_reg(rbp_pkg::REG_CY, 32'hFFF);
        write_reg(rbp_pkg::REG_HW, 32'hFF);
        write_reg(rbp_pkg::REG_HH, 32'd0);
        send_blip(24'sd0, 24'sd0, 24'sd0, 24'sd0, 16'h1234);
        send_blip(24'sd1, 24'sd0, 24'sd0, 24'sd0, 16'h1234);
        send_random(150);
        wait_drained();
        write_reg(rbp_pkg::REG_RADIUS, 32'h3FF);
        write_reg(rbp_pkg::REG_CX, 32'hFFF);
        write_reg(rbp_pkg::REG_HW, 32'd0);
        write_reg(rbp_pkg::REG_HH, 32'hFF);
        send_random(200);
        wait_drained();
        write_reg(rbp_pkg::REG_SCALE, 32'd0);
        send_random(50);
        wait_drained();
    endtask

    task automatic test_random_config();
        for (int p = 0; p < 4; p++) begin
            write_reg(rbp_pkg::REG_SCALE, $urandom_range(0, 65535));
            write_reg(rbp_pkg::REG_RADIUS, $urandom_range(0, 1023));
            write_reg(rbp_pkg::REG_CX, $urandom_range(0, 4095));
            write_reg(rbp_pkg::REG_CY, $urandom_range(0, 4095));
            write_reg(rbp_pkg::REG_HW, $urandom_range(0, 255));
            write_reg(rbp_pkg::REG_HH, $urandom_range(0, 255));
            send_random(250);
            wait_drained();
        end
    endtask

    task automatic test_backpressure();
        write_reg(rbp_pkg::REG_SCALE, 32'd6554);
        write_reg(rbp_pkg::REG_RADIUS, 32'd64);
        hold_cycles = 200;
        send_random(150);
        wait_drained();
    endtask

    task automatic test_no_idle();
        send_gaps = 1'b0;
        sink_gaps = 1'b0;
        send_random(180);
        wait_drained();
    endtask

    // Receiver: random stall bursts, plus a long hold-off when requested.
    initial begin
        int burst;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                i_stall <= 1'b1;
                repeat (hold_cycles) @(posedge i_clk);
                hold_cycles = 0;
                i_stall <= 1'b0;
            end else if (sink_gaps && $urandom_range(0, 4) == 0) begin
                burst = $urandom_range(1, 4);
                i_stall <= 1'b1;
                repeat (burst) @(posedge i_clk);
                i_stall <= 1'b0;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Result checker: every accepted output beat against the oldest prediction.
    always @(posedge i_clk) begin
        blip_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_blips.size() == 0) begin
                $error("unexpected output beat: pixel_x %0d pixel_y %0d", o_pixel_x, o_pixel_y);
                errors++;
            end else begin
                want = expected_blips.pop_front();
                if (o_pixel_x !== want.px) begin
                    $error("pixel_x expected %0d actual %0d", want.px, o_pixel_x);
                    errors++;
                end
                if (o_pixel_y !== want.py) begin
                    $error("pixel_y expected %0d actual %0d", want.py, o_pixel_y);
                    errors++;
                end
                if (o_clamped !== want.clamped) begin
                    $error("clamped expected %0d actual %0d", want.clamped, o_clamped);
                    errors++;
                end
            end
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_extreme_config();
        test_random_config();
        test_backpressure();
        test_no_idle();
        if (expected_blips.size() != 0) begin
            $error("%0d expected beats never arrived", expected_blips.size());
            errors++;
        end
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #5ms;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
